// ===== sv/chip8_instruction_execute_assert.svh =====
// Assertion macros for the instruction execute block.
// Used by chip8_instruction_execute.sv; no other dependencies.
`ifndef CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
// implication checked on every edge outside reset
`define C8_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define C8_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ===== sv/c8ie_pkg.sv =====
// Shared constants for the instruction execute block.
// No dependencies.
package c8ie_pkg;
   localparam int MEM_BYTES_DEF   = 4096;
   localparam int SCREEN_W_DEF    = 64;
   localparam int SCREEN_H_DEF    = 32;
   localparam int STACK_DEPTH_DEF = 16;
   localparam logic [11:0] FONT_BASE_RST = 12'd80;
   localparam logic [11:0] PROG_START_RST = 12'd512;
   localparam logic [1:0] ACT_EXEC = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;
   localparam logic [1:0] ACT_TICK = 2'd3;
   localparam logic [0:0] CSR_FONT_BASE = 1'b0;
   localparam logic [0:0] CSR_PROG_START = 1'b1;
endpackage

// ===== sv/chip8_instruction_execute.sv =====
// Memory write, read and tick answer straight from idle; opcodes go through an execute state,
// and sprite draw, FX55, FX65, FX33, 00EE and 00E0 step through further states before the result.
// Throughput: one item at a time; the next beat is taken in the cycle the result leaves.
// Reset (synchronous, active high) clears registers, timers, stack pointer, then sweeps
// the display clear row by row, no beat taken; memory and stack undefined.
module chip8_instruction_execute #(
   parameter int MEM_BYTES   = c8ie_pkg::MEM_BYTES_DEF,
   parameter int SCREEN_W    = c8ie_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H    = c8ie_pkg::SCREEN_H_DEF,
   parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [11:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_opcode,
   input  logic [15:0] req_keys,
   input  logic [7:0]  req_random_byte,
   input  logic [11:0] req_mem_addr,
   input  logic [7:0]  req_mem_data,
   input  logic [4:0]  req_row_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_pc_now,
   output logic [11:0] rsp_index_now,
   output logic [7:0]  rsp_flag_reg,
   output logic        rsp_key_wait,
   output logic        rsp_sound_on,
   output logic [7:0]  rsp_read_byte,
   output logic [63:0] rsp_row_pixels,
   output logic        rsp_stack_fault
);
   import c8ie_pkg::*;
`include "chip8_instruction_execute_assert.svh"

   localparam int AW = $clog2(MEM_BYTES);
   localparam int RW = $clog2(SCREEN_H);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(SCREEN_W);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_EXEC, S_DRAW_RD, S_DRAW_WAIT, S_DRAW_WR,
      S_STORE, S_LOAD_RD, S_LOAD_WR, S_BCD, S_RET, S_RESP
   } state_type;

   // memories
   logic [7:0]  mem [MEM_BYTES];
   logic [63:0] frame [SCREEN_H];
   logic [11:0] stack [STACK_DEPTH];

   logic        mem_we, fr_we, st_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]  mem_wd, mem_rd_ff;
   logic [RW-1:0] fr_wa, fr_ra;
   logic [63:0] fr_wd, fr_rd_ff;
   logic [SW-1:0] st_wa, st_ra;
   logic [11:0] st_wd, st_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd_ff <= mem[mem_ra];
      if (fr_we) frame[fr_wa] <= fr_wd;
      fr_rd_ff <= frame[fr_ra];
      if (st_we) stack[st_wa] <= st_wd;
      st_rd_ff <= stack[st_ra];
   end

   state_type   state_ff, state_in;
   logic [7:0]  v_ff [16];
   logic [7:0]  v_in [16];
   logic [11:0] pc_ff, pc_in, i_ff, i_in, font_ff;
   logic [SW-1:0] sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic [15:0] op_ff, op_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        hit_ff, hit_in;
   logic [RW-1:0] y0_ff, y0_in;
   logic [CW-1:0] x0_ff, x0_in;
   logic [7:0]  bits_ff, bits_in;
   logic        rv_ff, rv_in, kw_ff, kw_in, sf_ff, sf_in;
   logic [7:0]  rb_ff, rb_in;
   logic [63:0] row_ff, row_in;
   logic        rdrow_ff, rdrow_in, rdbyte_ff, rdbyte_in;

   logic [3:0] ox, oy, on;
   logic [7:0] vx, vy, kk;
   logic [8:0] sum9;
   logic [4:0] key_idx;
   logic [7:0] q100, r100, q10, r10;
   logic [63:0] sprite_mask, spr_wide;
   logic [11:0] font_off;

   logic [15:0] keys_ff;
   logic [7:0] rnd_ff;
   logic [1:0] act_ff;
   logic [AW-1:0] addr_ff;
   logic [7:0] data_ff;
   logic [RW-1:0] rsel_ff;

   assign ox = op_ff[11:8];
   assign oy = op_ff[7:4];
   assign on = op_ff[3:0];
   assign kk = op_ff[7:0];
   assign vx = v_ff[ox];
   assign vy = v_ff[oy];
   assign sum9 = {1'b0, vx} + {1'b0, vy};
   assign font_off = {2'b0, vx, 2'b0} + {4'b0, vx};

   // BCD: hundreds by compare-subtract, tens by multiply-shift on narrow values
   always_comb begin
      q100 = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
      r100 = vx - 8'(q100 * 8'd100);
      q10 = 8'((16'(r100) * 16'd205) >> 11);
      r10 = r100 - 8'(q10 * 8'd10);
   end

   always_comb begin
      key_idx = 5'd16;
      for (int k = 15; k >= 0; k--) begin
         if (keys_ff[k]) key_idx = 5'(k);
      end
   end

   // sprite row placed at x0, clipped at the right edge
   always_comb begin
      spr_wide = {bits_ff, 56'b0} >> x0_ff;
      sprite_mask = '0;
      for (int c = 0; c < SCREEN_W; c++) sprite_mask[63-c] = 1'b1;
      spr_wide = spr_wide & sprite_mask;
   end

   // a waiting result holds off the next beat
   assign req_stall = (state_ff != S_IDLE) || (rv_ff && rsp_stall);
   wire req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff <= req_action;
         keys_ff <= req_keys;
         rnd_ff <= req_random_byte;
         addr_ff <= req_mem_addr[AW-1:0];
         data_ff <= req_mem_data;
         rsel_ff <= req_row_select[RW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      for (int j = 0; j < 16; j++) v_in[j] = v_ff[j];
      pc_in = pc_ff; i_in = i_ff; sp_in = sp_ff; dt_in = dt_ff; st_in = st_ff;
      op_in = op_ff; cnt_in = cnt_ff; hit_in = hit_ff; y0_in = y0_ff; x0_in = x0_ff;
      bits_in = bits_ff; rv_in = rv_ff; kw_in = kw_ff; sf_in = sf_ff;
      rb_in = rb_ff; row_in = row_ff; rdrow_in = rdrow_ff; rdbyte_in = rdbyte_ff;
      mem_we = 1'b0; mem_wa = addr_ff; mem_wd = data_ff; mem_ra = addr_ff;
      fr_we = 1'b0; fr_wa = RW'(cnt_ff); fr_wd = '0; fr_ra = rsel_ff;
      st_we = 1'b0; st_wa = sp_ff; st_wd = pc_ff; st_ra = sp_ff - SW'(1);
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            fr_we = 1'b1;
            fr_wa = RW'(cnt_ff);
            cnt_in = cnt_ff + 5'd1;
            // 00E0 answers once the sweep is done; the sweep after reset does not
            if (cnt_ff == 5'(SCREEN_H - 1))
               state_in = (op_ff == 16'h00E0) ? S_RESP : S_IDLE;
         end
         S_IDLE: begin
            if (req_take) begin
               op_in = req_opcode;
               kw_in = 1'b0; sf_in = 1'b0; rb_in = '0; row_in = '0;
               rdrow_in = 1'b0; rdbyte_in = 1'b0;
               state_in = S_RESP;
               unique case (req_action)
                  ACT_EXEC: state_in = S_EXEC;
                  ACT_WRITE: begin
                     mem_we = 1'b1; mem_wa = req_mem_addr[AW-1:0];
                     mem_wd = req_mem_data;
                  end
                  ACT_READ: begin
                     mem_ra = req_mem_addr[AW-1:0];
                     fr_ra = req_row_select[RW-1:0];
                     rdrow_in = 1'b1; rdbyte_in = 1'b1;
                  end
                  ACT_TICK: begin
                     if (dt_ff != 0) dt_in = dt_ff - 8'd1;
                     if (st_ff != 0) st_in = st_ff - 8'd1;
                  end
               endcase
            end
         end
         S_EXEC: begin
            pc_in = pc_ff + 12'd2;
            state_in = S_RESP;
            cnt_in = '0;
            unique case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00E0) begin
                     state_in = S_CLEAR;
                  end else if (op_ff == 16'h00EE) begin
                     sf_in = (sp_ff == '0);
                     sp_in = (sp_ff == '0) ? SW'(STACK_DEPTH - 1) : sp_ff - SW'(1);
                     state_in = S_RET;
                  end
               end
               4'h1: pc_in = op_ff[11:0];
               4'h2: begin
                  st_we = 1'b1; st_wd = pc_ff + 12'd2;
                  sf_in = (sp_ff == SW'(STACK_DEPTH - 1));
                  sp_in = (sp_ff == SW'(STACK_DEPTH - 1)) ? '0 : sp_ff + SW'(1);
                  pc_in = op_ff[11:0];
               end
               4'h3: if (vx == kk) pc_in = pc_ff + 12'd4;
               4'h4: if (vx != kk) pc_in = pc_ff + 12'd4;
               4'h5: if (vx == vy) pc_in = pc_ff + 12'd4;
               4'h6: v_in[ox] = kk;
               4'h7: v_in[ox] = vx + kk;
               4'h8: begin
                  unique case (on)
                     4'h0: v_in[ox] = vy;
                     4'h1: v_in[ox] = vx | vy;
                     4'h2: v_in[ox] = vx & vy;
                     4'h3: v_in[ox] = vx ^ vy;
                     4'h4: begin v_in[ox] = sum9[7:0]; v_in[15] = {7'b0, sum9[8]}; end
                     4'h5: begin v_in[ox] = vx - vy; v_in[15] = {7'b0, vx > vy}; end
                     4'h6: begin v_in[ox] = vy >> 1; v_in[15] = {7'b0, vy[0]}; end
                     4'h7: begin v_in[ox] = vy - vx; v_in[15] = {7'b0, vy > vx}; end
                     4'hE: begin v_in[ox] = vy << 1; v_in[15] = {7'b0, vy[7]}; end
                     default: ;
                  endcase
               end
               4'h9: if (vx != vy) pc_in = pc_ff + 12'd4;
               4'hA: i_in = op_ff[11:0];
               4'hB: pc_in = {4'b0, v_ff[0]} + op_ff[11:0];
               4'hC: v_in[ox] = rnd_ff & kk;
               4'hD: begin
                  x0_in = vx[CW-1:0];
                  y0_in = vy[RW-1:0];
                  hit_in = 1'b0;
                  state_in = S_DRAW_RD;
               end
               4'hE: begin
                  if (kk == 8'h9E && keys_ff[vx[3:0]]) pc_in = pc_ff + 12'd4;
                  else if (kk == 8'hA1 && !keys_ff[vx[3:0]]) pc_in = pc_ff + 12'd4;
               end
               4'hF: begin
                  unique case (kk)
                     8'h07: v_in[ox] = dt_ff;
                     8'h0A: begin
                        if (key_idx[4]) begin pc_in = pc_ff; kw_in = 1'b1; end
                        else v_in[ox] = {4'b0, key_idx[3:0]};
                     end
                     8'h15: dt_in = vx;
                     8'h18: st_in = vx;
                     8'h1E: i_in = i_ff + {4'b0, vx};
                     8'h29: i_in = font_ff + font_off;
                     8'h33: state_in = S_BCD;
                     8'h55: state_in = S_STORE;
                     8'h65: state_in = S_LOAD_RD;
                     default: ;
                  endcase
               end
            endcase
         end
         S_RET: begin
            // read issued with the decremented pointer; data lands next cycle
            st_ra = sp_ff;
            state_in = S_RESP;
            cnt_in = 5'd1;
         end
         S_DRAW_RD: begin
            if (cnt_ff >= {1'b0, on} || (6'(y0_ff) + 6'(cnt_ff)) >= 6'(SCREEN_H)) begin
               v_in[15] = {7'b0, hit_ff};
               state_in = S_RESP;
            end else begin
               mem_ra = AW'(i_ff + {7'b0, cnt_ff});
               fr_ra = RW'(y0_ff + RW'(cnt_ff));
               state_in = S_DRAW_WAIT;
            end
         end
         S_DRAW_WAIT: begin
            bits_in = mem_rd_ff;
            row_in = fr_rd_ff;
            state_in = S_DRAW_WR;
         end
         S_DRAW_WR: begin
            fr_we = 1'b1;
            fr_wa = RW'(y0_ff + RW'(cnt_ff));
            fr_wd = row_ff ^ spr_wide;
            if ((row_ff & spr_wide) != '0) hit_in = 1'b1;
            row_in = '0;
            cnt_in = cnt_ff + 5'd1;
            state_in = S_DRAW_RD;
         end
         S_STORE: begin
            mem_we = 1'b1;
            mem_wa = AW'(i_ff + {7'b0, cnt_ff});
            mem_wd = v_ff[cnt_ff[3:0]];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff[3:0] == ox) state_in = S_RESP;
         end
         S_LOAD_RD: begin
            mem_ra = AW'(i_ff + {7'b0, cnt_ff});
            state_in = S_LOAD_WR;
         end
         S_LOAD_WR: begin
            v_in[cnt_ff[3:0]] = mem_rd_ff;
            cnt_in = cnt_ff + 5'd1;
            state_in = (cnt_ff[3:0] == ox) ? S_RESP : S_LOAD_RD;
         end
         S_BCD: begin
            mem_we = 1'b1;
            mem_wa = AW'(i_ff + {7'b0, cnt_ff});
            mem_wd = (cnt_ff == 5'd0) ? q100 : ((cnt_ff == 5'd1) ? q10 : r10);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd2) state_in = S_RESP;
         end
         S_RESP: begin
            // return address arrives first; the beat goes out the cycle after
            if (act_ff == ACT_EXEC && op_ff == 16'h00EE && cnt_ff == 5'd1) begin
               pc_in = st_rd_ff;
               cnt_in = '0;
            end else if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               if (rdrow_ff) begin row_in = fr_rd_ff; rb_in = mem_rd_ff; end
               else row_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         for (int j = 0; j < 16; j++) v_ff[j] <= '0;
         pc_ff <= PROG_START_RST; i_ff <= '0; sp_ff <= '0; dt_ff <= '0; st_ff <= '0;
         font_ff <= FONT_BASE_RST;
         cnt_ff <= '0; rv_ff <= 1'b0; op_ff <= '0; rdrow_ff <= 1'b0; rdbyte_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         for (int j = 0; j < 16; j++) v_ff[j] <= v_in[j];
         pc_ff <= pc_in; i_ff <= i_in; sp_ff <= sp_in; dt_ff <= dt_in; st_ff <= st_in;
         cnt_ff <= cnt_in; rv_ff <= rv_in; op_ff <= op_in;
         rdrow_ff <= rdrow_in; rdbyte_ff <= rdbyte_in;
         if (csr_write) begin
            // writes to program start are ignored; reset always loads its default
            unique case (csr_index)
               CSR_FONT_BASE: font_ff <= csr_data;
               CSR_PROG_START: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in; y0_ff <= y0_in; x0_ff <= x0_in; bits_ff <= bits_in;
      kw_ff <= kw_in; sf_ff <= sf_in; rb_ff <= rb_in; row_ff <= row_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_pc_now = pc_ff;
   assign rsp_index_now = i_ff;
   assign rsp_flag_reg = v_ff[15];
   assign rsp_key_wait = kw_ff;
   assign rsp_sound_on = (st_ff != 8'd0);
   assign rsp_read_byte = rdbyte_ff ? rb_ff : 8'd0;
   assign rsp_row_pixels = rdrow_ff ? row_ff : 64'd0;
   assign rsp_stack_fault = sf_ff;

   `C8_ASSERT_IMP(a_no_take_busy, clock, reset, state_ff != S_IDLE, req_stall)
   `C8_ASSERT_NXT(a_hold_rsp, clock, reset, rv_ff && rsp_stall, rv_ff && $stable(pc_ff))
   `C8_ASSERT_IMP(a_kw_exec, clock, reset, rv_ff && kw_ff, act_ff == ACT_EXEC)
endmodule

// ===== sim/c8ie_tb_pkg.sv =====
// Opcode field codes shared by the instruction execute testbench and its checker.
// No dependencies.
package c8ie_tb_pkg;
   // top nibble of the instruction word
   localparam logic [3:0] OP_SYS     = 4'h0;
   localparam logic [3:0] OP_JP      = 4'h1;
   localparam logic [3:0] OP_CALL    = 4'h2;
   localparam logic [3:0] OP_SE_IMM  = 4'h3;
   localparam logic [3:0] OP_SNE_IMM = 4'h4;
   localparam logic [3:0] OP_SE_REG  = 4'h5;
   localparam logic [3:0] OP_LD_IMM  = 4'h6;
   localparam logic [3:0] OP_ADD_IMM = 4'h7;
   localparam logic [3:0] OP_ALU     = 4'h8;
   localparam logic [3:0] OP_SNE_REG = 4'h9;
   localparam logic [3:0] OP_LD_I    = 4'hA;
   localparam logic [3:0] OP_JP_V0   = 4'hB;
   localparam logic [3:0] OP_RND     = 4'hC;
   localparam logic [3:0] OP_DRW     = 4'hD;
   localparam logic [3:0] OP_SKEY    = 4'hE;
   localparam logic [3:0] OP_MISC    = 4'hF;
   // ALU low nibble
   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;
   // low byte selectors
   localparam logic [7:0] KEY_SKP    = 8'h9E;
   localparam logic [7:0] KEY_SKNP   = 8'hA1;
   localparam logic [7:0] F_GET_DT   = 8'h07;
   localparam logic [7:0] F_WAIT_KEY = 8'h0A;
   localparam logic [7:0] F_SET_DT   = 8'h15;
   localparam logic [7:0] F_SET_ST   = 8'h18;
   localparam logic [7:0] F_ADD_I    = 8'h1E;
   localparam logic [7:0] F_FONT     = 8'h29;
   localparam logic [7:0] F_BCD      = 8'h33;
   localparam logic [7:0] F_STORE    = 8'h55;
   localparam logic [7:0] F_LOAD     = 8'h65;
   localparam logic [15:0] SYS_CLS   = 16'h00E0;
   localparam logic [15:0] SYS_RET   = 16'h00EE;
endpackage

// ===== sim/c8ie_checker.sv =====
// Checker for the instruction execute block: predicts every result beat from the
// accepted request beats and compares it field by field.
// Depends on c8ie_pkg and c8ie_tb_pkg.
module c8ie_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [11:0] csr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_opcode,
   input  logic [15:0] req_keys,
   input  logic [7:0]  req_random_byte,
   input  logic [11:0] req_mem_addr,
   input  logic [7:0]  req_mem_data,
   input  logic [4:0]  req_row_select,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [11:0] rsp_pc_now,
   input  logic [11:0] rsp_index_now,
   input  logic [7:0]  rsp_flag_reg,
   input  logic        rsp_key_wait,
   input  logic        rsp_sound_on,
   input  logic [7:0]  rsp_read_byte,
   input  logic [63:0] rsp_row_pixels,
   input  logic        rsp_stack_fault,
   output int          mismatches,
   output int          pending,
   output int          beats_checked
);
   import c8ie_pkg::*;
   import c8ie_tb_pkg::*;

   typedef struct packed {
      logic [11:0] pc;
      logic [11:0] idx;
      logic [7:0]  flag;
      logic        kw;
      logic        snd;
      logic [7:0]  rbyte;
      logic [63:0] row;
      logic        sf;
   } cpu_view_type;

   logic [7:0]  vreg [16];
   logic [11:0] pc, ireg;
   logic [11:0] ret_stack [16];
   logic [3:0]  sp;
   logic [7:0]  mem [4096];
   logic [63:0] frame [32];
   logic [7:0]  delay_t, sound_t;
   logic [11:0] font_base;
   cpu_view_type expected_views [$];

   function automatic void draw(logic [3:0] x, logic [3:0] y, logic [3:0] n);
      int x0, y0;
      logic [7:0] bits;
      logic [63:0] m;
      logic hit;
      x0 = vreg[x] % 64;
      y0 = vreg[y] % 32;
      hit = 0;
      for (int r = 0; r < n && y0 + r < 32; r++) begin
         bits = mem[ireg + 12'(r)];
         for (int c = 0; c < 8 && x0 + c < 64; c++) begin
            if (bits[7 - c]) begin
               m = 64'd1 << (63 - (x0 + c));
               if ((frame[y0 + r] & m) != 0) hit = 1;
               frame[y0 + r] ^= m;
            end
         end
      end
      vreg[15] = {7'd0, hit};
   endfunction

   function automatic void run_opcode(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd,
                                      output logic kw, output logic sf);
      logic [3:0] x, y, n;
      logic [7:0] kk, vx, vy;
      logic [11:0] nnn;
      logic [8:0] sum;
      int k;
      x = op[11:8];
      y = op[7:4];
      n = op[3:0];
      kk = op[7:0];
      nnn = op[11:0];
      vx = vreg[x];
      vy = vreg[y];
      kw = 0;
      sf = 0;
      pc = pc + 12'd2;
      case (op[15:12])
         OP_SYS: begin
            if (op == SYS_CLS) begin
               foreach (frame[i]) frame[i] = '0;
            end else if (op == SYS_RET) begin
               if (sp == 0) sf = 1;
               sp = sp - 4'd1;
               pc = ret_stack[sp];
            end
         end
         OP_JP: pc = nnn;
         OP_CALL: begin
            ret_stack[sp] = pc;
            if (sp == 4'hF) sf = 1;
            sp = sp + 4'd1;
            pc = nnn;
         end
         OP_SE_IMM:  if (vx == kk) pc = pc + 12'd2;
         OP_SNE_IMM: if (vx != kk) pc = pc + 12'd2;
         OP_SE_REG:  if (vx == vy) pc = pc + 12'd2;
         OP_LD_IMM:  vreg[x] = kk;
         OP_ADD_IMM: vreg[x] = vx + kk;
         OP_ALU: begin
            // VX first, VF last, so X = F ends up holding the flag
            case (n)
               ALU_MOV: vreg[x] = vy;
               ALU_OR:  vreg[x] = vx | vy;
               ALU_AND: vreg[x] = vx & vy;
               ALU_XOR: vreg[x] = vx ^ vy;
               ALU_ADD: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  vreg[x] = sum[7:0];
                  vreg[15] = {7'd0, sum[8]};
               end
               ALU_SUB: begin
                  vreg[x] = vx - vy;
                  vreg[15] = {7'd0, vx > vy};
               end
               ALU_SHR: begin
                  vreg[x] = vy >> 1;
                  vreg[15] = {7'd0, vy[0]};
               end
               ALU_SUBN: begin
                  vreg[x] = vy - vx;
                  vreg[15] = {7'd0, vy > vx};
               end
               ALU_SHL: begin
                  vreg[x] = vy << 1;
                  vreg[15] = {7'd0, vy[7]};
               end
               default: ;
            endcase
         end
         OP_SNE_REG: if (vx != vy) pc = pc + 12'd2;
         OP_LD_I:    ireg = nnn;
         OP_JP_V0:   pc = nnn + {4'd0, vreg[0]};
         OP_RND:     vreg[x] = rnd & kk;
         OP_DRW:     draw(x, y, n);
         OP_SKEY: begin
            if (kk == KEY_SKP && keys[vx[3:0]]) pc = pc + 12'd2;
            else if (kk == KEY_SKNP && !keys[vx[3:0]]) pc = pc + 12'd2;
         end
         default: begin
            case (kk)
               F_GET_DT: vreg[x] = delay_t;
               F_WAIT_KEY: begin
                  k = 16;
                  for (int i = 15; i >= 0; i--) if (keys[i]) k = i;
                  if (k < 16) vreg[x] = 8'(k);
                  else begin
                     pc = pc - 12'd2;
                     kw = 1;
                  end
               end
               F_SET_DT: delay_t = vx;
               F_SET_ST: sound_t = vx;
               F_ADD_I:  ireg = ireg + {4'd0, vx};
               F_FONT:   ireg = font_base + {4'd0, vx} * 12'd5;
               F_BCD: begin
                  mem[ireg] = vx / 8'd100;
                  mem[ireg + 12'd1] = (vx / 8'd10) % 8'd10;
                  mem[ireg + 12'd2] = vx % 8'd10;
               end
               F_STORE: for (int i = 0; i <= x; i++) mem[ireg + 12'(i)] = vreg[i];
               F_LOAD:  for (int i = 0; i <= x; i++) vreg[i] = mem[ireg + 12'(i)];
               default: ;
            endcase
         end
      endcase
   endfunction

   function automatic cpu_view_type step_item();
      cpu_view_type e;
      logic kw, sf;
      kw = 0;
      sf = 0;
      e.rbyte = '0;
      e.row = '0;
      case (req_action)
         ACT_EXEC:  run_opcode(req_opcode, req_keys, req_random_byte, kw, sf);
         ACT_WRITE: mem[req_mem_addr] = req_mem_data;
         ACT_READ: begin
            e.rbyte = mem[req_mem_addr];
            e.row = frame[req_row_select];
         end
         default: begin
            if (delay_t != 0) delay_t = delay_t - 8'd1;
            if (sound_t != 0) sound_t = sound_t - 8'd1;
         end
      endcase
      e.pc = pc;
      e.idx = ireg;
      e.flag = vreg[15];
      e.kw = kw;
      e.snd = sound_t != 0;
      e.sf = sf;
      return e;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("beat %0d: %s expected %h got %h", beats_checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      cpu_view_type e;
      if (reset) begin
         foreach (vreg[i]) vreg[i] = '0;
         foreach (frame[i]) frame[i] = '0;
         font_base = FONT_BASE_RST;
         pc = PROG_START_RST;
         ireg = '0;
         sp = '0;
         delay_t = '0;
         sound_t = '0;
         mismatches = 0;
         beats_checked = 0;
         expected_views.delete();
      end else begin
         if (csr_write && csr_index == CSR_FONT_BASE) font_base = csr_data;
         if (req_valid && !req_stall) expected_views.push_back(step_item());
         if (rsp_valid && !rsp_stall) begin
            if (expected_views.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("result beat with nothing expected");
            end else begin
               e = expected_views.pop_front();
               check_field("pc_now", e.pc, rsp_pc_now);
               check_field("index_now", e.idx, rsp_index_now);
               check_field("flag_reg", e.flag, rsp_flag_reg);
               check_field("key_wait", e.kw, rsp_key_wait);
               check_field("sound_on", e.snd, rsp_sound_on);
               check_field("read_byte", e.rbyte, rsp_read_byte);
               check_field("row_pixels", e.row, rsp_row_pixels);
               check_field("stack_fault", e.sf, rsp_stack_fault);
            end
            beats_checked++;
         end
      end
      pending = expected_views.size();
   end
endmodule

// ===== sim/testbench.sv =====
// Top of the instruction execute testbench: clock, reset, stimulus and verdict.
// Depends on chip8_instruction_execute, c8ie_checker, c8ie_pkg and c8ie_tb_pkg.
module testbench;
   import c8ie_pkg::*;
   import c8ie_tb_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [0:0]  csr_index = '0;
   logic [11:0] csr_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_EXEC;
   logic [15:0] req_opcode = '0;
   logic [15:0] req_keys = '0;
   logic [7:0]  req_random_byte = '0;
   logic [11:0] req_mem_addr = '0;
   logic [7:0]  req_mem_data = '0;
   logic [4:0]  req_row_select = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [11:0] rsp_pc_now, rsp_index_now;
   logic [7:0]  rsp_flag_reg, rsp_read_byte;
   logic        rsp_key_wait, rsp_sound_on, rsp_stack_fault;
   logic [63:0] rsp_row_pixels;
   int          mismatches, pending, beats_checked;
   int          items_sent = 0;
   bit          gaps_on = 0;

   chip8_instruction_execute i_dut (.*);

   c8ie_checker i_chk (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // response side: random stall before each beat while gaps are on
   initial begin
      int n;
      forever begin
         n = gaps_on ? $urandom_range(0, 6) : 0;
         if (n > 0) begin
            rsp_stall = 1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      #4000000;
      $display("[chip8_instruction_execute] ERROR");
      $finish;
   end

   function automatic logic [15:0] mk_op(logic [3:0] hi, logic [3:0] x, logic [7:0] lo);
      return {hi, x, lo};
   endfunction

   task automatic send(logic [1:0] act, logic [15:0] op, logic [15:0] keys,
                       logic [7:0] rnd, logic [11:0] addr, logic [7:0] data,
                       logic [4:0] row);
      int gap;
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1;
      req_action = act;
      req_opcode = op;
      req_keys = keys;
      req_random_byte = rnd;
      req_mem_addr = addr;
      req_mem_data = data;
      req_row_select = row;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic exec(logic [15:0] op, logic [15:0] keys = 16'hFFFF, logic [7:0] rnd = 8'hFF);
      send(ACT_EXEC, op, keys, rnd, 12'($urandom), 8'($urandom), 5'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (pending != 0) @(negedge clock);
      // longest beat is a full-height sprite; let it settle
      repeat (64) @(negedge clock);
   endtask

   task automatic csr_put(logic [0:0] idx, logic [11:0] val);
      @(negedge clock);
      csr_write = 1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 0;
   endtask

   function automatic logic [15:0] pick_keys();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 16'd1 << $urandom_range(0, 15);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_opcode();
      logic [3:0] hi, x;
      logic [7:0] lo;
      logic [7:0] misc_sel [9] = '{F_GET_DT, F_WAIT_KEY, F_SET_DT, F_SET_ST, F_ADD_I,
                                   F_FONT, F_BCD, F_STORE, F_LOAD};
      hi = 4'($urandom);
      x = 4'($urandom);
      lo = 8'($urandom);
      case (hi)
         OP_SYS: case ($urandom_range(0, 4))
            0: return SYS_CLS;
            1, 2: return SYS_RET;
            default: return 16'($urandom_range(0, 4095));
         endcase
         OP_SKEY: if ($urandom_range(0, 4) != 0)
            lo = $urandom_range(0, 1) ? KEY_SKP : KEY_SKNP;
         OP_MISC: if ($urandom_range(0, 7) != 0) lo = misc_sel[$urandom_range(0, 8)];
         OP_SE_IMM, OP_SNE_IMM: if ($urandom_range(0, 1)) lo = {4'd0, 4'($urandom)};
         default: ;
      endcase
      return mk_op(hi, x, lo);
   endfunction

   task automatic random_beats(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) gaps_on = $urandom_range(0, 3) != 0;
         if (i == count / 2) begin
            // hold off until everything in flight has come back
            @(negedge clock);
            req_valid = 0;
            while (pending != 0) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 72) exec(pick_opcode(), pick_keys(), 8'($urandom));
         else if (r < 82)
            send(ACT_WRITE, 16'($urandom), 16'($urandom), 8'($urandom), 12'($urandom),
                 8'($urandom), 5'($urandom));
         else if (r < 92)
            send(ACT_READ, 16'($urandom), 16'($urandom), 8'($urandom), 12'($urandom),
                 8'($urandom), 5'($urandom));
         else
            send(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 12'($urandom),
                 8'($urandom), 5'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      csr_put(CSR_FONT_BASE, 12'd0);
      csr_put(CSR_PROG_START, 12'hFFF);

      // fill all of memory and every stack slot so no read ever hits an unwritten entry
      for (int r = 0; r < 16; r++) exec(mk_op(OP_LD_IMM, 4'(r), 8'($urandom)));
      for (int b = 0; b < 256; b++) begin
         exec(mk_op(OP_LD_I, 4'(b >> 4), {4'(b), 4'h0}));
         exec(mk_op(OP_MISC, 4'hF, F_STORE));
      end
      for (int s = 0; s < 16; s++) exec(mk_op(OP_CALL, 4'($urandom), 8'($urandom)));

      gaps_on = 1;
      exec(mk_op(OP_LD_IMM, 4'h0, 8'hFF));
      exec(mk_op(OP_LD_IMM, 4'h1, 8'h01));
      exec(mk_op(OP_ALU, 4'h0, {4'h1, ALU_ADD}));            // carry out
      exec(mk_op(OP_ALU, 4'h0, {4'h1, ALU_SUB}));
      exec(mk_op(OP_ALU, 4'h1, {4'h0, ALU_SUBN}));
      exec(mk_op(OP_ALU, 4'h2, {4'h0, ALU_SHR}));
      exec(mk_op(OP_ALU, 4'h2, {4'h0, ALU_SHL}));
      exec(mk_op(OP_ALU, 4'hF, {4'h0, ALU_ADD}));            // flag wins over VX
      exec(mk_op(OP_LD_IMM, 4'h0, 8'hFF));
      exec(mk_op(OP_JP_V0, 4'hF, 8'hFF));                    // pc wrap
      exec(mk_op(OP_LD_I, 4'hF, 8'hFE));
      exec(mk_op(OP_MISC, 4'h0, F_ADD_I));                   // I wrap
      exec(mk_op(OP_MISC, 4'h0, F_FONT));
      exec(mk_op(OP_MISC, 4'h0, F_BCD));
      exec(mk_op(OP_MISC, 4'hF, F_STORE));
      exec(mk_op(OP_MISC, 4'hF, F_LOAD));
      exec(mk_op(OP_MISC, 4'h3, F_WAIT_KEY), 16'h0000);      // no key, rewind
      exec(mk_op(OP_MISC, 4'h3, F_WAIT_KEY), 16'h8000);
      exec(mk_op(OP_LD_IMM, 4'h4, 8'h3F));
      exec(mk_op(OP_LD_IMM, 4'h5, 8'hFF));
      exec(mk_op(OP_DRW, 4'h4, 8'h5F));                      // clipped at the corner
      exec(mk_op(OP_DRW, 4'h4, 8'h50));                      // zero height
      send(ACT_READ, '0, '0, '0, 12'hFFF, '0, 5'd31);
      exec(SYS_RET);                                         // pointer at zero: underflow
      exec(mk_op(OP_MISC, 4'h5, F_SET_ST));
      send(ACT_TICK, '0, '0, '0, '0, '0, '0);
      exec(SYS_CLS);
      drain();

      csr_put(CSR_FONT_BASE, 12'hFFF);
      random_beats(350);
      drain();
      csr_put(CSR_FONT_BASE, 12'($urandom));
      csr_put(CSR_PROG_START, 12'd0);
      random_beats(350);
      drain();
      csr_put(CSR_FONT_BASE, FONT_BASE_RST);
      csr_put(CSR_PROG_START, PROG_START_RST);
      random_beats(350);
      drain();

      $display("Sent %0d beats: memory filled by register stores, stack wrap, directed",
               items_sent);
      $display("corner cases and random opcodes over four font bases; %0d results compared.",
               beats_checked);
      if (mismatches == 0) $display("[chip8_instruction_execute] OK");
      else $display("[chip8_instruction_execute] ERROR");
      $finish;
   end
endmodule
